### hdl/mscp_pkg.sv
package mscp_pkg;

	localparam logic [7:0] CODE_SEQ = 8'hB3;
	localparam logic [7:0] CODE_PIC = 8'h00;
	localparam logic [7:0] CODE_GOP = 8'hB8;
	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE = 8'h01;

	localparam logic [2:0] CT_I = 3'd1;
	localparam logic [2:0] CT_P = 3'd2;
	localparam logic [2:0] CT_B = 3'd3;

	typedef enum logic [1:0] {
		KIND_SEQ   = 2'd0,
		KIND_PIC   = 2'd1,
		KIND_GOP   = 2'd2,
		KIND_OTHER = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  code_byte;
		logic [11:0] width;
		logic [11:0] height;
		logic [3:0]  rate_code;
		logic [15:0] rate_millifps;
		logic [2:0]  coding_type;
		logic [1:0]  picture_class;
	} result_t;

	// Frame rate in thousandths of a frame per second.
	function automatic logic [15:0] rate_lookup(input logic [3:0] rc);
		logic [15:0] r;
		unique case (rc)
			4'd1: r = 16'd23976;
			4'd2: r = 16'd24000;
			4'd3: r = 16'd25000;
			4'd4: r = 16'd29970;
			4'd5: r = 16'd30000;
			4'd6: r = 16'd50000;
			4'd7: r = 16'd59940;
			4'd8: r = 16'd60000;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

### hdl/mpeg_start_code_header_parser.sv
// A result is registered: it is valid in the cycle after the byte that completes it is accepted.
// The parser takes one byte per clock; a byte is taken while a result waits in the
//   output register as long as that result is not stalled.
// The output register is the only buffer; the parse state lives in a small FSM.
// Reset (arst_n low, asynchronous) returns the FSM to prefix scanning with no
//   zeros counted, no bytes held and no result pending.
module mpeg_start_code_header_parser
	import mscp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [7:0]  code_byte,
	output logic [11:0] width,
	output logic [11:0] height,
	output logic [3:0]  rate_code,
	output logic [15:0] rate_millifps,
	output logic [2:0]  coding_type,
	output logic [1:0]  picture_class
);

	typedef enum logic [1:0] {
		ST_SCAN,   // sliding match on 00 00 01
		ST_CODE,   // next byte is the start code value
		ST_SEQ,    // collecting sequence header payload
		ST_PIC     // collecting picture header payload
	} state_t;

	state_t      state_q, state_d;
	logic [1:0]  zero_run_q, zero_run_d;
	logic [1:0]  taken_q, taken_d;
	logic [23:0] held_q, held_d;
	logic        out_valid_q;
	result_t     out_q;

	logic        accept;
	logic        emit;
	kind_t       res_kind;
	result_t     res;

	// Stall the source only while a finished request sits unread downstream.
	assign data_stall = out_valid_q && result_stall;
	assign accept     = data_valid && !data_stall;

	// One step of the parser for the byte on the port.
	always_comb begin
		state_d    = state_q;
		zero_run_d = zero_run_q;
		taken_d    = taken_q;
		held_d     = held_q;
		emit       = 1'b0;
		res_kind   = KIND_OTHER;
		unique case (state_q)
			ST_CODE: begin
				taken_d = 2'd0;
				held_d  = '0;
				if (data_byte == CODE_SEQ) begin
					state_d = ST_SEQ;
				end else if (data_byte == CODE_PIC) begin
					state_d = ST_PIC;
				end else begin
					// GOP and every other code report at once with no payload.
					emit       = 1'b1;
					res_kind   = (data_byte == CODE_GOP) ? KIND_GOP : KIND_OTHER;
					state_d    = ST_SCAN;
					zero_run_d = 2'd0;
				end
			end
			ST_SEQ: begin
				if (taken_q != 2'd3) begin
					// Shift in the first three payload bytes, newest low.
					held_d  = {held_q[15:0], data_byte};
					taken_d = taken_q + 2'd1;
				end else begin
					emit       = 1'b1;
					res_kind   = KIND_SEQ;
					state_d    = ST_SCAN;
					zero_run_d = 2'd0;
					taken_d    = 2'd0;
					held_d     = '0;
				end
			end
			ST_PIC: begin
				if (taken_q == 2'd0) begin
					// The first picture payload byte carries nothing we report.
					held_d  = {16'd0, data_byte};
					taken_d = 2'd1;
				end else begin
					emit       = 1'b1;
					res_kind   = KIND_PIC;
					state_d    = ST_SCAN;
					zero_run_d = 2'd0;
					taken_d    = 2'd0;
					held_d     = '0;
				end
			end
			default: begin
				// Count zeros, saturating at two; longer runs still form a prefix.
				if (data_byte == BYTE_ONE && zero_run_q == 2'd2) begin
					state_d    = ST_CODE;
					zero_run_d = 2'd0;
				end else if (data_byte == BYTE_ZERO) begin
					zero_run_d = (zero_run_q == 2'd2) ? 2'd2 : zero_run_q + 2'd1;
				end else begin
					zero_run_d = 2'd0;
				end
			end
		endcase
	end

	mscp_fields u_fields (
		.kind      (res_kind),
		.held      (held_q),
		.last_byte (data_byte),
		.res       (res)
	);

	// Advance the FSM on each accepted byte; load the output register on a result
	// and drop the request once downstream takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SCAN;
			zero_run_q  <= 2'd0;
			taken_q     <= 2'd0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (accept) begin
				state_q    <= state_d;
				zero_run_q <= zero_run_d;
				taken_q    <= taken_d;
				held_q     <= held_d;
			end
			if (accept && emit) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid  = out_valid_q;
	assign kind          = out_q.kind;
	assign code_byte     = out_q.code_byte;
	assign width         = out_q.width;
	assign height        = out_q.height;
	assign rate_code     = out_q.rate_code;
	assign rate_millifps = out_q.rate_millifps;
	assign coding_type   = out_q.coding_type;
	assign picture_class = out_q.picture_class;

`ifndef ASSERT_OFF
	a_restart_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit) |=> (state_q == ST_SCAN && zero_run_q == 2'd0 && taken_q == 2'd0))
		else $error("parser did not restart scanning after a result");

	a_seq_code_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((out_q.kind == KIND_SEQ) == (code_byte == CODE_SEQ)))
		else $error("sequence header kind and code byte disagree");

	a_non_seq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && out_q.kind != KIND_SEQ) |->
			(width == 12'd0 && height == 12'd0 && rate_code == 4'd0 &&
			 rate_millifps == 16'd0))
		else $error("sequence fields set on a result that is not a sequence header");

	a_class_follows_type: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && picture_class != 2'd0) |->
			(out_q.kind == KIND_PIC && coding_type == {1'b0, picture_class}))
		else $error("picture class does not follow coding type");
`endif

endmodule

### hdl/mscp_fields.sv
// Build the result fields from the held header bytes and the last byte.
module mscp_fields
	import mscp_pkg::*;
(
	input  kind_t       kind,
	input  logic [23:0] held,
	input  logic [7:0]  last_byte,
	output result_t     res
);

	logic [2:0] ct;

	assign ct = last_byte[5:3];

	always_comb begin
		res = '0;
		res.kind = kind;
		unique case (kind)
			KIND_SEQ: begin
				res.code_byte     = CODE_SEQ;
				res.width         = {held[23:16], held[15:12]};
				res.height        = {held[11:8], held[7:0]};
				res.rate_code     = last_byte[3:0];
				res.rate_millifps = rate_lookup(last_byte[3:0]);
			end
			KIND_PIC: begin
				res.code_byte   = CODE_PIC;
				res.coding_type = ct;
				if (ct == CT_I || ct == CT_P || ct == CT_B) begin
					res.picture_class = ct[1:0];
				end
			end
			default: begin
				res.code_byte = last_byte;
			end
		endcase
	end

endmodule

### tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mscp_pkg::*;

	// Pack and system header codes; the parser reports both as plain codes.
	localparam logic [7:0] CODE_PACK   = 8'hBA;
	localparam logic [7:0] CODE_SYSTEM = 8'hBB;

	// A result shows up in the cycle after its last byte is taken; pad the settle time a little.
	localparam int DRAIN_CYCLES = 4;
	localparam int RANDOM_BYTES = 500;

	typedef enum logic [2:0] {
		PH_SCAN = 3'd0,
		PH_CODE = 3'd1,
		PH_SEQ  = 3'd2,
		PH_PIC  = 3'd3
	} parse_phase_t;

	logic        clk;
	logic        arst_n;
	logic        data_valid;
	logic        data_stall;
	logic [7:0]  data_byte;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  kind;
	logic [7:0]  code_byte;
	logic [11:0] width;
	logic [11:0] height;
	logic [3:0]  rate_code;
	logic [15:0] rate_millifps;
	logic [2:0]  coding_type;
	logic [1:0]  picture_class;

	// Parser state as seen by the testbench, mirrored byte by byte.
	parse_phase_t scan_phase;
	logic [1:0]   zeros_seen;
	logic [1:0]   payload_count;
	logic [23:0]  payload_bytes;

	// Header reports that the block still owes us, oldest first.
	result_t parsed_codes[$];

	int  mismatches;
	int  results_seen;
	int  bytes_sent;
	int  burst_left;
	bit  sender_bursty;
	int  rx_hold_cycles;
	int  rx_count;
	int  rx_mode;

	mpeg_start_code_header_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_valid    (data_valid),
		.data_stall    (data_stall),
		.data_byte     (data_byte),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.kind          (kind),
		.code_byte     (code_byte),
		.width         (width),
		.height        (height),
		.rate_code     (rate_code),
		.rate_millifps (rate_millifps),
		.coding_type   (coding_type),
		.picture_class (picture_class)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Drop the run if it hangs; the slowest legal run is far shorter than this.
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Frame rate in thousandths of a frame per second for each rate code.
	function automatic logic [15:0] milli_fps(input logic [3:0] rc);
		logic [15:0] fps;
		case (rc)
			4'd1: fps = 16'd23976;
			4'd2: fps = 16'd24000;
			4'd3: fps = 16'd25000;
			4'd4: fps = 16'd29970;
			4'd5: fps = 16'd30000;
			4'd6: fps = 16'd50000;
			4'd7: fps = 16'd59940;
			4'd8: fps = 16'd60000;
			default: fps = 16'd0;
		endcase
		return fps;
	endfunction

	// Advance the mirrored parser by one accepted byte and queue any report it completes.
	task automatic parse_byte(input logic [7:0] b);
		result_t    rpt;
		logic       done;
		logic [2:0] ct;
		rpt = '0;
		done = 1'b0;
		ct = b[5:3];
		case (scan_phase)
			PH_CODE: begin
				if (b == CODE_SEQ) begin
					scan_phase = PH_SEQ;
					payload_count = 2'd0;
					payload_bytes = '0;
				end else if (b == CODE_PIC) begin
					scan_phase = PH_PIC;
					payload_count = 2'd0;
					payload_bytes = '0;
				end else begin
					rpt.kind = (b == CODE_GOP) ? KIND_GOP : KIND_OTHER;
					rpt.code_byte = b;
					done = 1'b1;
				end
			end
			PH_SEQ: begin
				// Hold three bytes; the fourth carries the rate code and closes the header.
				if (payload_count < 2'd3) begin
					payload_bytes = {payload_bytes[15:0], b};
					payload_count = payload_count + 2'd1;
				end else begin
					rpt.kind = KIND_SEQ;
					rpt.code_byte = CODE_SEQ;
					rpt.width = {payload_bytes[23:16], payload_bytes[15:12]};
					rpt.height = payload_bytes[11:0];
					rpt.rate_code = b[3:0];
					rpt.rate_millifps = milli_fps(b[3:0]);
					done = 1'b1;
				end
			end
			PH_PIC: begin
				// Skip the temporal reference byte; the next one carries the coding type.
				if (payload_count == 2'd0) begin
					payload_bytes = {16'h0000, b};
					payload_count = 2'd1;
				end else begin
					rpt.kind = KIND_PIC;
					rpt.code_byte = CODE_PIC;
					rpt.coding_type = ct;
					if (ct == CT_I || ct == CT_P || ct == CT_B)
						rpt.picture_class = ct[1:0];
					done = 1'b1;
				end
			end
			default: begin
				// Sliding prefix match: any run of two or more zeros followed by a one.
				scan_phase = PH_SCAN;
				if (b == BYTE_ONE && zeros_seen == 2'd2) begin
					scan_phase = PH_CODE;
					zeros_seen = 2'd0;
				end else if (b == BYTE_ZERO) begin
					if (zeros_seen != 2'd2)
						zeros_seen = zeros_seen + 2'd1;
				end else begin
					zeros_seen = 2'd0;
				end
			end
		endcase
		if (done) begin
			parsed_codes.push_back(rpt);
			scan_phase = PH_SCAN;
			zeros_seen = 2'd0;
			payload_count = 2'd0;
			payload_bytes = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0h, want %0h (result %0d)",
			$realtime, what, got, want, results_seen);
		mismatches++;
	endtask

	// Check every result taken from the block against the oldest queued report.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (parsed_codes.size() == 0) begin
				report_mismatch("unexpected result, kind", kind, 0);
			end else begin
				want = parsed_codes.pop_front();
				if (kind !== want.kind)
					report_mismatch("kind", kind, want.kind);
				if (code_byte !== want.code_byte)
					report_mismatch("code_byte", code_byte, want.code_byte);
				if (width !== want.width)
					report_mismatch("width", width, want.width);
				if (height !== want.height)
					report_mismatch("height", height, want.height);
				if (rate_code !== want.rate_code)
					report_mismatch("rate_code", rate_code, want.rate_code);
				if (rate_millifps !== want.rate_millifps)
					report_mismatch("rate_millifps", rate_millifps, want.rate_millifps);
				if (coding_type !== want.coding_type)
					report_mismatch("coding_type", coding_type, want.coding_type);
				if (picture_class !== want.picture_class)
					report_mismatch("picture_class", picture_class, want.picture_class);
			end
			results_seen++;
		end
	end

	// Result side: a long hold-off when asked, otherwise a stall pattern that
	// switches at random between open, coin-flip, mostly-stalled and rare.
	initial begin
		result_stall = 1'b0;
		rx_count = 0;
		rx_mode = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				result_stall <= 1'b1;
				rx_hold_cycles--;
			end else begin
				case (rx_mode)
					0: result_stall <= 1'b0;
					1: result_stall <= 1'($urandom_range(0, 1));
					2: result_stall <= (rx_count % 4 != 0);
					default: result_stall <= ($urandom_range(0, 7) == 0);
				endcase
			end
			rx_count++;
			if (rx_count % 64 == 0)
				rx_mode = $urandom_range(0, 3);
		end
	end

	// Offer one byte and hold it until the block takes the request. In bursty
	// mode, close a burst with a random gap before the next request goes out.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		@(negedge clk);
		data_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (data_stall);
		parse_byte(b);
		bytes_sent++;
		if (sender_bursty) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 8);
				burst_left = $urandom_range(0, 40);
				@(negedge clk);
				data_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_prefix(input int zeros);
		repeat (zeros) send_byte(BYTE_ZERO);
		send_byte(BYTE_ONE);
	endtask

	// Lower valid and wait for every queued report, then let the block settle.
	task automatic drain_results();
		@(negedge clk);
		data_valid <= 1'b0;
		while (parsed_codes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Payload and noise bytes lean toward zero and one so stray prefixes turn up.
	function automatic logic [7:0] pick_byte();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 2)
			return BYTE_ZERO;
		if (sel == 2)
			return BYTE_ONE;
		return 8'($urandom_range(0, 255));
	endfunction

	// A lone zero before a one is no prefix; a long zero run still is one.
	task automatic test_prefix_search();
		send_byte(BYTE_ZERO);
		send_byte(BYTE_ONE);
		send_prefix(4);
		send_byte(CODE_PACK);
	endtask

	// All-ones payload gives the largest sizes and an unknown rate code; a
	// payload that holds a prefix must be taken as payload, not searched.
	task automatic test_sequence_header();
		send_prefix(2);
		send_byte(CODE_SEQ);
		repeat (4) send_byte(8'hFF);
		send_prefix(2);
		send_byte(CODE_SEQ);
		send_byte(BYTE_ZERO);
		send_byte(BYTE_ZERO);
		send_byte(BYTE_ONE);
		send_byte(8'h18);
	endtask

	task automatic test_picture_header();
		send_prefix(2);
		send_byte(CODE_PIC);
		send_byte(8'hFF);
		send_byte({2'b11, CT_B, 3'b111});
	endtask

	task automatic test_gop_and_other();
		send_prefix(2);
		send_byte(CODE_GOP);
		send_prefix(3);
		send_byte(CODE_SYSTEM);
	endtask

	// Hold off the result side for a long stretch while a run of GOP codes keeps
	// coming, so the output register fills and the block stalls its input.
	task automatic test_output_backpressure();
		drain_results();
		sender_bursty = 1'b0;
		rx_hold_cycles = 120;
		repeat (12) begin
			send_prefix(2);
			send_byte(CODE_GOP);
		end
		drain_results();
		sender_bursty = 1'b1;
	endtask

	// Mostly well-formed start codes with random content; the rest is broken
	// prefixes and noise.
	task automatic test_random_stream();
		int         start;
		int         sel;
		logic [7:0] code;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			sel = $urandom_range(0, 99);
			if (sel < 85)
				send_prefix($urandom_range(2, 4));
			if (sel < 30) begin
				send_byte(CODE_SEQ);
				repeat (3) send_byte(pick_byte());
				send_byte(8'($urandom_range(0, 255)));
			end else if (sel < 55) begin
				send_byte(CODE_PIC);
				send_byte(pick_byte());
				send_byte(pick_byte());
			end else if (sel < 65) begin
				send_byte(CODE_GOP);
			end else if (sel < 80) begin
				code = 8'($urandom_range(1, 255));
				if (code == CODE_SEQ)
					code = CODE_PACK;
				send_byte(code);
			end else if (sel >= 85) begin
				repeat ($urandom_range(1, 6)) send_byte(pick_byte());
			end
			// Prefixes left hanging (sel 80..84) run straight into the next unit.
		end
	endtask

	initial begin
		arst_n = 1'b0;
		data_valid = 1'b0;
		data_byte = 8'h00;
		mismatches = 0;
		results_seen = 0;
		bytes_sent = 0;
		burst_left = 0;
		sender_bursty = 1'b1;
		rx_hold_cycles = 0;
		scan_phase = PH_SCAN;
		zeros_seen = 2'd0;
		payload_count = 2'd0;
		payload_bytes = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_prefix_search();
		test_sequence_header();
		test_picture_header();
		test_gop_and_other();
		test_output_backpressure();
		test_random_stream();
		drain_results();

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### files.f
hdl/mscp_pkg.sv
hdl/mscp_fields.sv
hdl/mpeg_start_code_header_parser.sv
tb/tb.sv
